### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### hw/rtl/smn_pkg.sv
// Package for sparse_matrix_norm_unit: widths, codes, queue record type.
// No dependencies.
package smn_pkg;
	localparam int MaxDim = 1024;
	localparam int IdxW = $clog2(MaxDim);
	localparam int CntW = IdxW + 1;
	localparam int RegIdxW = 2;
	localparam int CfgW = 11;
	localparam int SumW = 48;
	localparam int SqW = 64;
	localparam int QDepth = 2;

	localparam logic [RegIdxW-1:0] RegNormKind = 2'd0;
	localparam logic [RegIdxW-1:0] RegSymmetric = 2'd1;
	localparam logic [RegIdxW-1:0] RegMatrixSize = 2'd2;
	localparam logic [RegIdxW-1:0] RegIndexBase = 2'd3;

	typedef enum logic [1:0] {
		KindMax = 2'd0,
		KindOne = 2'd1,
		KindInf = 2'd2,
		KindFrob = 2'd3
	} kind_t;

	// classified entry handed from the front to the back
	typedef struct packed {
		logic in_range;
		logic mirror;
		logic last;
		logic [IdxW-1:0] first_idx;
		logic [IdxW-1:0] second_idx;
		logic [SqW-1:0] sq;
	} work_t;

	typedef enum logic [3:0] {
		StIdle,
		StRoot,
		StRd1,
		StWr1,
		StRd2,
		StWr2,
		StScanRd,
		StScan,
		StFinStart,
		StFinRoot,
		StOut,
		StClear
	} state_t;
endpackage

### hw/rtl/smn_stream_if.sv
// Valid/ready channel interfaces for the norm unit.
// Depends on smn_pkg.
interface smn_entry_if;
	logic valid;
	logic ready;
	logic [10:0] row_index;
	logic [10:0] column_index;
	logic signed [31:0] real_part;
	logic signed [31:0] imag_part;
	logic last_entry;
	modport source(output valid, row_index, column_index, real_part, imag_part, last_entry,
		input ready);
	modport sink(input valid, row_index, column_index, real_part, imag_part, last_entry,
		output ready);
endinterface

interface smn_result_if;
	logic valid;
	logic ready;
	logic [smn_pkg::SumW-1:0] norm_value;
	logic saturated;
	modport source(output valid, norm_value, saturated, input ready);
	modport sink(input valid, norm_value, saturated, output ready);
endinterface

### hw/rtl/smn_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
module smn_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

### hw/rtl/smn_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on smn_pkg.
module smn_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [smn_pkg::SqW-1:0]   value,
	output logic                      done,
	output logic [31:0]               root
);
	logic [smn_pkg::SqW-1:0] rem_q, res_q, bit_q;
	logic busy_q;
	logic [smn_pkg::SqW-1:0] trial;
	assign trial = res_q + bit_q;
	assign root = res_q[31:0];
	assign done = busy_q && (bit_q == '0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q && bit_q != '0) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

### hw/rtl/smn_front.sv
// Front: accepts entries, squares and range-checks them, fills the work queue.
// Depends on smn_pkg and smn_stream_if.
module smn_front (
	input  logic               clk,
	input  logic               arst_n,
	smn_entry_if.sink          entry,
	input  logic               symmetric,
	input  logic [10:0]        matrix_size,
	input  logic               index_base,
	input  logic [1:0]         norm_kind,
	output smn_pkg::work_t     work,
	output logic               work_valid,
	input  logic               work_ready
);
	// stage 1: absolute values and indices
	logic v_s1, v_s2;
	logic [31:0] re_s1, im_s1;
	logic [63:0] re2_s2, im2_s2;
	logic rng_s1, rng_s2, mir_s1, mir_s2, last_s1, last_s2;
	logic [smn_pkg::IdxW-1:0] a_s1, b_s1, a_s2, b_s2;
	smn_pkg::work_t q_q [smn_pkg::QDepth];
	logic [$clog2(smn_pkg::QDepth)-1:0] wp_q, rp_q;
	logic [$clog2(smn_pkg::QDepth+1)-1:0] cnt_q;
	logic [10:0] size, r, c;
	logic ok, adv, push, pop;

	always_comb begin
		size = (matrix_size > 11'(smn_pkg::MaxDim)) ? 11'(smn_pkg::MaxDim) : matrix_size;
		r = entry.row_index - 11'(index_base);
		c = entry.column_index - 11'(index_base);
		ok = (entry.row_index >= 11'(index_base)) && (entry.column_index >= 11'(index_base))
			&& (r < size) && (c < size);
	end

	// pipeline moves when its tail has space; two stages plus queue
	assign push = v_s2 && (cnt_q < $bits(cnt_q)'(smn_pkg::QDepth));
	assign adv = !v_s2 || push;
	assign entry.ready = adv;
	assign pop = work_valid && work_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= entry.valid;
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			re_s1 <= entry.real_part[31] ? 32'(-entry.real_part) : entry.real_part;
			im_s1 <= entry.imag_part[31] ? 32'(-entry.imag_part) : entry.imag_part;
			rng_s1 <= ok;
			mir_s1 <= symmetric && (r != c);
			last_s1 <= entry.last_entry;
			if (norm_kind == smn_pkg::KindInf) begin
				a_s1 <= r[smn_pkg::IdxW-1:0];
				b_s1 <= c[smn_pkg::IdxW-1:0];
			end else begin
				a_s1 <= c[smn_pkg::IdxW-1:0];
				b_s1 <= r[smn_pkg::IdxW-1:0];
			end
			re2_s2 <= 64'(re_s1) * 64'(re_s1);
			im2_s2 <= 64'(im_s1) * 64'(im_s1);
			rng_s2 <= rng_s1;
			mir_s2 <= mir_s1;
			last_s2 <= last_s1;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + $bits(cnt_q)'(push) - $bits(cnt_q)'(pop);
		end
	end
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= '{in_range: rng_s2, mirror: mir_s2, last: last_s2,
				first_idx: a_s2, second_idx: b_s2, sq: re2_s2 + im2_s2};
		end
	end
	assign work = q_q[rp_q];
	assign work_valid = cnt_q != '0;
endmodule

### hw/rtl/smn_back.sv
// Back: accumulates the selected norm, scans line sums and returns the result.
// Depends on smn_pkg, smn_ram, smn_isqrt, smn_stream_if.
module smn_back (
	input  logic               clk,
	input  logic               arst_n,
	input  smn_pkg::work_t     work,
	input  logic               work_valid,
	output logic               work_ready,
	input  logic [1:0]         norm_kind,
	input  logic [10:0]        matrix_size,
	smn_result_if.source       result
);
	localparam int W = smn_pkg::SumW;
	smn_pkg::state_t st_q, st_d;
	smn_pkg::work_t w_q;
	logic [W-1:0] mag_q, max_q, res_q;
	logic [63:0] sqsum_q;
	logic ovf_q;
	logic [smn_pkg::CntW-1:0] cnt_q;
	logic [smn_pkg::IdxW-1:0] addr;
	logic we;
	logic [W-1:0] wdata, rdata;
	logic sq_start, sq_done;
	logic [63:0] sq_in;
	logic [31:0] root;
	logic [W:0] lsum;
	logic [64:0] term, fsum;
	logic [10:0] size;
	logic kind_line;

	assign size = (matrix_size > 11'(smn_pkg::MaxDim)) ? 11'(smn_pkg::MaxDim) : matrix_size;
	assign kind_line = (norm_kind == smn_pkg::KindOne) || (norm_kind == smn_pkg::KindInf);

	smn_ram #(.Width(W), .Depth(smn_pkg::MaxDim)) u_sums (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));
	smn_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .value(sq_in),
		.done(sq_done), .root(root));

	assign lsum = {1'b0, rdata} + {1'b0, mag_q};
	// Frobenius term of the entry at the queue head, doubled when mirrored
	assign term = work.mirror ? {work.sq, 1'b0} : {1'b0, work.sq};
	assign fsum = {1'b0, sqsum_q} + term;

	always_comb begin
		st_d = st_q;
		case (st_q)
			smn_pkg::StIdle: if (work_valid) begin
				// a dropped last entry still closes the matrix
				if (!work.in_range) begin
					if (!work.last) st_d = smn_pkg::StIdle;
					else if (norm_kind == smn_pkg::KindFrob) st_d = smn_pkg::StFinStart;
					else if (kind_line) st_d = smn_pkg::StScanRd;
					else st_d = smn_pkg::StOut;
				end else if (norm_kind == smn_pkg::KindFrob)
					st_d = work.last ? smn_pkg::StFinStart : smn_pkg::StIdle;
				else st_d = smn_pkg::StRoot;
			end
			smn_pkg::StRoot: if (sq_done) st_d = kind_line ? smn_pkg::StRd1 :
				(w_q.last ? smn_pkg::StOut : smn_pkg::StIdle);
			smn_pkg::StRd1: st_d = smn_pkg::StWr1;
			smn_pkg::StWr1: st_d = w_q.mirror ? smn_pkg::StRd2 :
				(w_q.last ? smn_pkg::StScanRd : smn_pkg::StIdle);
			smn_pkg::StRd2: st_d = smn_pkg::StWr2;
			smn_pkg::StWr2: st_d = w_q.last ? smn_pkg::StScanRd : smn_pkg::StIdle;
			smn_pkg::StScanRd: st_d = (cnt_q >= smn_pkg::CntW'(size)) ? smn_pkg::StOut
				: smn_pkg::StScan;
			smn_pkg::StScan: st_d = smn_pkg::StScanRd;
			smn_pkg::StFinStart: st_d = smn_pkg::StFinRoot;
			smn_pkg::StFinRoot: if (sq_done) st_d = smn_pkg::StOut;
			smn_pkg::StOut: if (result.ready) st_d = smn_pkg::StClear;
			smn_pkg::StClear: if (cnt_q == smn_pkg::CntW'(smn_pkg::MaxDim - 1))
				st_d = smn_pkg::StIdle;
			default: st_d = smn_pkg::StIdle;
		endcase
	end

	always_comb begin
		work_ready = (st_q == smn_pkg::StIdle);
		sq_start = 1'b0;
		sq_in = w_q.sq;
		we = 1'b0;
		wdata = lsum[W] ? {W{1'b1}} : lsum[W-1:0];
		addr = w_q.first_idx;
		case (st_q)
			smn_pkg::StIdle: begin
				sq_in = work.sq;
				sq_start = work_valid && work.in_range && norm_kind != smn_pkg::KindFrob;
			end
			smn_pkg::StWr1: we = 1'b1;
			smn_pkg::StRd2, smn_pkg::StWr2: begin
				addr = w_q.second_idx;
				we = (st_q == smn_pkg::StWr2);
			end
			smn_pkg::StScanRd, smn_pkg::StScan: addr = cnt_q[smn_pkg::IdxW-1:0];
			smn_pkg::StFinStart: begin
				sq_in = sqsum_q;
				sq_start = 1'b1;
			end
			smn_pkg::StClear: begin
				addr = cnt_q[smn_pkg::IdxW-1:0];
				we = 1'b1;
				wdata = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= smn_pkg::StClear;
		else st_q <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			max_q <= '0;
			sqsum_q <= '0;
			ovf_q <= 1'b0;
			res_q <= '0;
		end else begin
			case (st_q)
				smn_pkg::StIdle: begin
					cnt_q <= '0;
					if (work_valid && work.in_range && norm_kind == smn_pkg::KindFrob) begin
						if (fsum[64] || (work.mirror && work.sq[63])) begin
							sqsum_q <= '1;
							ovf_q <= 1'b1;
						end else begin
							sqsum_q <= fsum[63:0];
						end
					end
				end
				smn_pkg::StRoot: if (sq_done && norm_kind == smn_pkg::KindMax
					&& W'(root) > max_q) max_q <= W'(root);
				smn_pkg::StWr1, smn_pkg::StWr2: if (lsum[W]) ovf_q <= 1'b1;
				smn_pkg::StScanRd: res_q <= (cnt_q == '0) ? '0 : res_q;
				smn_pkg::StScan: begin
					if (rdata > res_q) res_q <= rdata;
					cnt_q <= cnt_q + 1'b1;
				end
				smn_pkg::StOut: begin
					cnt_q <= '0;
				end
				smn_pkg::StClear: begin
					cnt_q <= cnt_q + 1'b1;
					max_q <= '0;
					sqsum_q <= '0;
					ovf_q <= 1'b0;
				end
				default: ;
			endcase
			if (st_q == smn_pkg::StFinRoot && sq_done) res_q <= W'(root);
			if (st_q == smn_pkg::StRoot && sq_done && w_q.last
				&& norm_kind == smn_pkg::KindMax)
				res_q <= (W'(root) > max_q) ? W'(root) : max_q;
			if (st_q == smn_pkg::StIdle && work_valid && !work.in_range && work.last
				&& norm_kind == smn_pkg::KindMax)
				res_q <= max_q;
		end
	end

	// held entry and its magnitude for the line sum update
	always_ff @(posedge clk) begin
		if (st_q == smn_pkg::StIdle && work_valid) w_q <= work;
		if (st_q == smn_pkg::StRoot && sq_done) mag_q <= W'(root);
	end

	assign result.valid = (st_q == smn_pkg::StOut);
	assign result.norm_value = res_q;
	assign result.saturated = ovf_q;
endmodule

### hw/rtl/sparse_matrix_norm_unit.sv
// Top level of the sparse matrix norm unit.
// Depends on smn_pkg, smn_stream_if, smn_front, smn_back, assert_macros.svh.
//
// Channels: entry (sink) takes one coordinate-form matrix entry a beat;
// result (source) gives one beat of norm_value/saturated per matrix, after
// the beat marked last_entry. cfg_we/cfg_index/cfg_data write registers.
// Front: two-stage square pipeline feeding a two-entry work queue.
// Back: per entry a bit-serial square root for the magnitude norms, then,
// for the one/inf norms, a read-modify-write of the line sum RAM (two when
// mirrored). Frobenius entries skip the root; it runs once at the end.
// The back takes a new entry from the work queue only once it is idle.
// The result follows a scan of the line sums within matrix_size for one/inf,
// the final root for Frobenius, or the last entry's root for the max norm.
// Reset: registers take their reset values and the back sweeps the 1024-entry
// sum RAM to zero before taking work; the same sweep follows every result
// beat. A stalled result holds its beat; the front keeps taking entries until
// the queue fills.
`include "assert_macros.svh"
module sparse_matrix_norm_unit (
	input  logic        clk,
	input  logic        arst_n,
	smn_entry_if.sink   entry,
	smn_result_if.source result,
	input  logic        cfg_we,
	input  logic [smn_pkg::RegIdxW-1:0] cfg_index,
	input  logic [smn_pkg::CfgW-1:0]    cfg_data
);
	logic [1:0] kind_q;
	logic sym_q, base_q;
	logic [10:0] size_q;
	smn_pkg::work_t work;
	logic work_valid, work_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= smn_pkg::KindMax;
			sym_q <= 1'b0;
			size_q <= 11'd1024;
			base_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				smn_pkg::RegNormKind: kind_q <= cfg_data[1:0];
				smn_pkg::RegSymmetric: sym_q <= cfg_data[0];
				smn_pkg::RegMatrixSize: size_q <= cfg_data;
				smn_pkg::RegIndexBase: base_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	smn_front u_front (
		.clk(clk), .arst_n(arst_n), .entry(entry), .symmetric(sym_q),
		.matrix_size(size_q), .index_base(base_q), .norm_kind(kind_q),
		.work(work), .work_valid(work_valid), .work_ready(work_ready));
	smn_back u_back (
		.clk(clk), .arst_n(arst_n), .work(work), .work_valid(work_valid),
		.work_ready(work_ready), .norm_kind(kind_q), .matrix_size(size_q),
		.result(result));

	`ASSERT_NEXT(a_res_hold, clk, arst_n, result.valid && !result.ready, result.valid)
	`ASSERT_IMPL(a_no_take_while_out, clk, arst_n, result.valid, !work_ready)
endmodule

### test/tb_sparse_matrix_norm_unit.sv
// Testbench for sparse_matrix_norm_unit: random and directed matrices, self-checking.
// Depends on smn_pkg, smn_stream_if and the RTL of the unit.
module tb_sparse_matrix_norm_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WatchdogLimit = 20000;
	// covers the clearing sweep, the widest line scan and the root, with queue slack
	localparam int unsigned SettleCycles = 3300;
	localparam logic [smn_pkg::SumW-1:0] LineMax = {smn_pkg::SumW{1'b1}};
	localparam logic [smn_pkg::SqW-1:0] SquareMax = {smn_pkg::SqW{1'b1}};

	typedef struct {
		logic [10:0] row;
		logic [10:0] col;
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic last;
	} coord_entry_t;

	typedef struct {
		logic [smn_pkg::SumW-1:0] value;
		logic sat;
	} norm_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [smn_pkg::RegIdxW-1:0] cfg_index;
	logic [smn_pkg::CfgW-1:0] cfg_data;

	smn_entry_if entry_ch();
	smn_result_if result_ch();

	sparse_matrix_norm_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.entry(entry_ch.sink),
		.result(result_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the register file, written alongside every cfg write
	smn_pkg::kind_t shadow_kind;
	logic shadow_sym;
	logic [10:0] shadow_size;
	logic shadow_base;

	// predictor state
	logic [smn_pkg::SumW-1:0] line_total [smn_pkg::MaxDim];
	logic [smn_pkg::SumW-1:0] peak_mag;
	logic [smn_pkg::SqW-1:0] square_total;
	logic sat_seen;

	coord_entry_t pending_entries[$];
	norm_result_t expected_norms[$];

	int unsigned errors;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// truncating integer square root, restoring method two bits a step
	function automatic logic [smn_pkg::SqW-1:0] int_root(input logic [smn_pkg::SqW-1:0] v);
		logic [smn_pkg::SqW-1:0] rem;
		logic [smn_pkg::SqW-1:0] root;
		logic [smn_pkg::SqW-1:0] probe;
		rem = v;
		root = '0;
		probe = 64'h1 << 62;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] q16_abs(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	task automatic add_to_line(input int unsigned idx, input logic [smn_pkg::SumW-1:0] mag);
		logic [smn_pkg::SumW:0] s;
		s = {1'b0, line_total[idx]} + mag;
		if (s > {1'b0, LineMax}) begin
			s = {1'b0, LineMax};
			sat_seen = 1'b1;
		end
		line_total[idx] = s[smn_pkg::SumW-1:0];
	endtask

	task automatic clear_sums();
		foreach (line_total[i])
			line_total[i] = '0;
		peak_mag = '0;
		square_total = '0;
		sat_seen = 1'b0;
	endtask

	// fold one accepted beat into the running norm; push a result on last_entry
	task automatic accumulate_entry(input coord_entry_t e);
		int unsigned eff;
		int unsigned r;
		int unsigned c;
		logic [31:0] ar;
		logic [31:0] ai;
		logic [smn_pkg::SqW-1:0] sq;
		logic [smn_pkg::SqW-1:0] mag;
		logic [smn_pkg::SqW-1:0] term;
		logic mirror;
		norm_result_t res;
		eff = (shadow_size > smn_pkg::MaxDim) ? smn_pkg::MaxDim : shadow_size;
		ar = q16_abs(e.re);
		ai = q16_abs(e.im);
		if (e.row >= shadow_base && e.col >= shadow_base) begin
			r = e.row - shadow_base;
			c = e.col - shadow_base;
			if (r < eff && c < eff) begin
				sq = 64'(ar) * 64'(ar) + 64'(ai) * 64'(ai);
				mag = int_root(sq);
				mirror = shadow_sym && (r != c);
				case (shadow_kind)
					smn_pkg::KindMax: begin
						if (mag[smn_pkg::SumW-1:0] > peak_mag)
							peak_mag = mag[smn_pkg::SumW-1:0];
					end
					smn_pkg::KindOne: begin
						add_to_line(c, mag[smn_pkg::SumW-1:0]);
						if (mirror)
							add_to_line(r, mag[smn_pkg::SumW-1:0]);
					end
					smn_pkg::KindInf: begin
						add_to_line(r, mag[smn_pkg::SumW-1:0]);
						if (mirror)
							add_to_line(c, mag[smn_pkg::SumW-1:0]);
					end
					default: begin
						term = sq;
						if (mirror) begin
							if (term > (SquareMax >> 1)) begin
								term = SquareMax;
								sat_seen = 1'b1;
							end else begin
								term = term << 1;
							end
						end
						if (square_total > SquareMax - term) begin
							square_total = SquareMax;
							sat_seen = 1'b1;
						end else begin
							square_total = square_total + term;
						end
					end
				endcase
			end
		end
		if (e.last) begin
			res.value = '0;
			case (shadow_kind)
				smn_pkg::KindMax: res.value = peak_mag;
				smn_pkg::KindFrob: res.value = int_root(square_total);
				default: begin
					for (int i = 0; i < eff; i++)
						if (line_total[i] > res.value)
							res.value = line_total[i];
				end
			endcase
			res.sat = sat_seen;
			expected_norms.push_back(res);
			clear_sums();
		end
	endtask

	// entry driver: a new beat is offered only once the previous one has gone
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_ch.valid <= 1'b0;
			entry_ch.row_index <= '0;
			entry_ch.column_index <= '0;
			entry_ch.real_part <= '0;
			entry_ch.imag_part <= '0;
			entry_ch.last_entry <= 1'b0;
		end else if (!entry_ch.valid || entry_ch.ready) begin
			if (pending_entries.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				entry_ch.valid <= 1'b1;
				entry_ch.row_index <= pending_entries[0].row;
				entry_ch.column_index <= pending_entries[0].col;
				entry_ch.real_part <= pending_entries[0].re;
				entry_ch.imag_part <= pending_entries[0].im;
				entry_ch.last_entry <= pending_entries[0].last;
				void'(pending_entries.pop_front());
			end else begin
				entry_ch.valid <= 1'b0;
			end
		end
	end

	// monitor: predict on accepted entries, check accepted results, back-pressure
	always @(posedge clk or negedge arst_n) begin
		coord_entry_t seen;
		norm_result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			if (entry_ch.valid && entry_ch.ready) begin
				seen.row = entry_ch.row_index;
				seen.col = entry_ch.column_index;
				seen.re = entry_ch.real_part;
				seen.im = entry_ch.imag_part;
				seen.last = entry_ch.last_entry;
				accumulate_entry(seen);
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_norms.size() == 0) begin
					$display("%0t: unexpected result beat norm_value=%h saturated=%b",
						$realtime, result_ch.norm_value, result_ch.saturated);
					errors++;
				end else begin
					want = expected_norms.pop_front();
					if (result_ch.norm_value !== want.value) begin
						$display("%0t: norm_value expected %h actual %h",
							$realtime, want.value, result_ch.norm_value);
						errors++;
					end
					if (result_ch.saturated !== want.sat) begin
						$display("%0t: saturated expected %b actual %b",
							$realtime, want.sat, result_ch.saturated);
						errors++;
					end
				end
			end
			// watchdog: any accepted beat on either side counts as progress
			if ((entry_ch.valid && entry_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("tb_sparse_matrix_norm_unit: FAIL");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [smn_pkg::RegIdxW-1:0] idx,
			input logic [smn_pkg::CfgW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			smn_pkg::RegNormKind: shadow_kind = smn_pkg::kind_t'(val[1:0]);
			smn_pkg::RegSymmetric: shadow_sym = val[0];
			smn_pkg::RegMatrixSize: shadow_size = val;
			default: shadow_base = val[0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input smn_pkg::kind_t k, input logic sym,
			input logic [10:0] size, input logic base);
		write_reg(smn_pkg::RegNormKind, smn_pkg::CfgW'(k));
		write_reg(smn_pkg::RegSymmetric, smn_pkg::CfgW'(sym));
		write_reg(smn_pkg::RegMatrixSize, size);
		write_reg(smn_pkg::RegIndexBase, smn_pkg::CfgW'(base));
	endtask

	// until every queued beat has gone and every result has come back
	task automatic drain();
		while (pending_entries.size() > 0 || entry_ch.valid || expected_norms.size() > 0)
			@(posedge clk);
	endtask

	task automatic queue_entry(input logic [10:0] r, input logic [10:0] c,
			input logic signed [31:0] re, input logic signed [31:0] im, input logic last);
		coord_entry_t e;
		e.row = r;
		e.col = c;
		e.re = re;
		e.im = im;
		e.last = last;
		pending_entries.push_back(e);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return $signed($urandom_range(32'h3_0000)) - 32'sh1_8000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [10:0] pick_index();
		int unsigned eff;
		eff = (shadow_size > smn_pkg::MaxDim) ? smn_pkg::MaxDim : shadow_size;
		if (eff == 0 || $urandom_range(9) == 0)
			return 11'($urandom_range(2047));
		return 11'(shadow_base + $urandom_range(eff - 1));
	endfunction

	// one matrix of random content; symmetric mode keeps to the lower triangle mostly
	task automatic queue_matrix(input int unsigned n);
		logic [10:0] r;
		logic [10:0] c;
		logic [10:0] t;
		for (int i = 0; i < n; i++) begin
			r = pick_index();
			c = pick_index();
			if (shadow_sym && r < c && $urandom_range(3) != 0) begin
				t = r;
				r = c;
				c = t;
			end
			queue_entry(r, c, pick_value(), ($urandom_range(3) == 0) ? '0 : pick_value(),
				i == n - 1);
		end
	endtask

	initial begin
		smn_pkg::kind_t kinds[4];
		logic [10:0] sizes[8];
		int unsigned idle_send[4];
		int unsigned idle_recv[4];
		int unsigned sent;
		int unsigned n;
		kinds = '{smn_pkg::KindMax, smn_pkg::KindOne, smn_pkg::KindInf, smn_pkg::KindFrob};
		sizes = '{11'd1024, 11'd1, 11'd2, 11'd7, 11'd0, 11'd2047, 11'd16, 11'd3};
		idle_send = '{0, 47, 0, 26};
		idle_recv = '{0, 0, 47, 26};
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		shadow_kind = smn_pkg::KindMax;
		shadow_sym = 1'b0;
		shadow_size = 11'd1024;
		shadow_base = 1'b0;
		clear_sums();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset config (max norm, size 1024, base 0), field extremes
		queue_entry(11'd0, 11'd0, 32'h8000_0000, 32'h8000_0000, 1'b0);
		queue_entry(11'd1023, 11'd1023, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
		queue_entry(11'd1024, 11'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0); // dropped row
		queue_entry(11'd2047, 11'd2047, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
		drain();
		repeat (SettleCycles) @(posedge clk);

		// Frobenius, mirrored: two full-scale off-diagonal squares saturate
		configure(smn_pkg::KindFrob, 1'b1, 11'd4, 1'b0);
		queue_entry(11'd1, 11'd0, 32'h8000_0000, 32'h8000_0000, 1'b0);
		queue_entry(11'd2, 11'd2, 32'h0001_0000, 32'h0000_0000, 1'b0);
		queue_entry(11'd3, 11'd1, 32'h8000_0000, 32'h0000_0000, 1'b1);
		drain();
		repeat (SettleCycles) @(posedge clk);

		// one-based indices, one norm: index 0 falls below the base and is dropped
		configure(smn_pkg::KindOne, 1'b1, 11'd3, 1'b1);
		queue_entry(11'd0, 11'd1, 32'h0010_0000, 32'h0000_0000, 1'b0);
		queue_entry(11'd3, 11'd1, 32'hFFF0_0000, 32'h0003_0000, 1'b0);
		queue_entry(11'd2, 11'd2, 32'h0002_0000, 32'hFFFE_0000, 1'b0);
		queue_entry(11'd4, 11'd1, 32'h0100_0000, 32'h0000_0000, 1'b1);
		drain();
		repeat (SettleCycles) @(posedge clk);

		// infinity norm, size 0: every entry dropped, result zero
		configure(smn_pkg::KindInf, 1'b0, 11'd0, 1'b0);
		queue_entry(11'd0, 11'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		// infinity norm, size above the maximum behaves as the maximum
		drain();
		repeat (SettleCycles) @(posedge clk);
		configure(smn_pkg::KindInf, 1'b1, 11'd2047, 1'b0);
		queue_entry(11'd1023, 11'd0, 32'h0001_0000, 32'h0001_0000, 1'b0);
		queue_entry(11'd1024, 11'd5, 32'h0001_0000, 32'h0001_0000, 1'b1);
		drain();
		repeat (SettleCycles) @(posedge clk);

		// random phases, cycling through the idling modes
		sent = 0;
		for (int ph = 0; sent < 1000; ph++) begin
			configure(kinds[ph % 4], 1'($urandom_range(1)), sizes[ph % 8],
				1'($urandom_range(1)));
			send_idle_pct = idle_send[(ph / 4) % 4];
			recv_stall_pct = idle_recv[(ph / 4) % 4];
			for (int m = 0; m < 8; m++) begin
				n = $urandom_range(1, 12);
				queue_matrix(n);
				sent += n;
				// sender holds back until every result so far is in
				if (m == 3)
					drain();
			end
			drain();
			repeat (SettleCycles) @(posedge clk);
		end

		if (errors == 0)
			$display("tb_sparse_matrix_norm_unit: PASS");
		else
			$display("tb_sparse_matrix_norm_unit: FAIL");
		$finish;
	end
endmodule
